// ===== rtl/core/bbcm_pkg.sv =====
// ============================================================================
// bbcm_pkg: shared types and constants for the block buffer cache manager
// Holds the payload structs, command and error codes, and the
// controller/datapath command and status bundles.
// ============================================================================
package bbcm_pkg;

  localparam int unsigned BUFFER_COUNT_DEF      = 16;
  localparam int unsigned BLOCK_NUMBER_BITS_DEF = 16;
  localparam int unsigned MAX_REFERENCES_DEF    = 255;

  typedef enum logic [1:0] {
    CMD_GET  = 2'd0,
    CMD_PUT  = 2'd1,
    CMD_SYNC = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ERR_OK       = 2'd0,
    ERR_ALL_BUSY = 2'd1,
    ERR_UNUSED   = 2'd2,
    ERR_OVERFLOW = 2'd3
  } err_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] block_number;
    logic        fetch_wanted;
    logic [3:0]  buffer_index;
    logic        to_front;
    logic        write_now;
    logic        modified;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  slot;
    logic        hit;
    logic        fetch_needed;
    logic        write_back_valid;
    logic [15:0] write_back_block;
    logic [1:0]  error_code;
    logic [4:0]  flushed_total;
    logic        last;
  } out_item_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;       // capture the input item, clear walk pointer
    logic match;      // run the tag match and register the result
    logic get_hit;    // commit or report a hit
    logic scan_step;  // examine one LRU position, advance pointer
    logic get_miss;   // take the victim found by the scan
    logic get_fail;   // report all busy
    logic put_check;  // validate put, decrement
    logic move_step;  // one shift of the LRU chain
    logic put_done;   // finish put result
    logic sync_step;  // examine one LRU position for dirty
    logic sync_done;  // final sync result
  } dp_cmd_t;

  typedef struct packed {
    logic       is_hit;
    logic       scan_found;
    logic       scan_end;
    logic       walk_end;
    logic       put_bad;
    logic       put_zero;
    logic       move_end;
    logic       sync_dirty;
    logic       out_full;
  } dp_stat_t;

endpackage

// ===== rtl/core/bbcm_datapath.sv =====
// ============================================================================
// bbcm_datapath: tag, count, dirty and LRU storage with walk logic
// One LRU position is examined or shifted per cycle, but scan and sync steps wait
// while a result is stalled; results go to an output register.
// ============================================================================
module bbcm_datapath #(
  parameter int unsigned BUFFER_COUNT      = bbcm_pkg::BUFFER_COUNT_DEF,
  parameter int unsigned BLOCK_NUMBER_BITS = bbcm_pkg::BLOCK_NUMBER_BITS_DEF,
  parameter int unsigned MAX_REFERENCES    = bbcm_pkg::MAX_REFERENCES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bbcm_pkg::in_item_t  in_data,
  input  bbcm_pkg::dp_cmd_t   cmd,
  output bbcm_pkg::dp_stat_t  stat,
  output logic                out_valid,
  input  logic                out_stall,
  output bbcm_pkg::out_item_t out_data
);

  localparam int unsigned IW = (BUFFER_COUNT > 1) ? $clog2(BUFFER_COUNT) : 1;
  localparam int unsigned PW = $clog2(BUFFER_COUNT + 1);
  localparam int unsigned CW = $clog2(MAX_REFERENCES + 1);
  localparam int unsigned BW = BLOCK_NUMBER_BITS;

  logic [BW-1:0] tag_mem [BUFFER_COUNT];
  logic [BUFFER_COUNT-1:0] valid_r, valid_nxt;
  logic [BUFFER_COUNT-1:0] dirty_r, dirty_nxt;
  logic [CW-1:0] cnt_r [BUFFER_COUNT];
  logic [CW-1:0] cnt_nxt [BUFFER_COUNT];
  logic [IW-1:0] lru_r [BUFFER_COUNT];
  logic [IW-1:0] lru_nxt [BUFFER_COUNT];
  logic [PW-1:0] busy_r, busy_nxt;

  bbcm_pkg::in_item_t item_r;
  logic [PW-1:0] ptr_r, ptr_nxt;
  logic [IW-1:0] hit_idx_r, hit_idx_nxt;
  logic          hit_r, hit_nxt;
  logic [PW-1:0] nflush_r, nflush_nxt;
  logic          tag_we;
  logic [IW-1:0] tag_wa;

  logic          ov_r, ov_nxt;
  bbcm_pkg::out_item_t od_r, od_nxt;

  logic [IW-1:0] cur_buf;
  logic [IW-1:0] pidx;
  logic [BW-1:0] cur_tag, pidx_tag;

  assign cur_buf = lru_r[ptr_r[IW-1:0]];
  assign cur_tag = tag_mem[cur_buf];
  assign pidx    = IW'(item_r.buffer_index);
  assign pidx_tag = tag_mem[pidx];

  always_comb begin
    stat = '0;
    stat.is_hit     = hit_r;
    stat.scan_found = (ptr_r < PW'(BUFFER_COUNT)) && (cnt_r[cur_buf] == '0);
    stat.scan_end   = (ptr_r >= PW'(BUFFER_COUNT)) || (busy_r >= PW'(BUFFER_COUNT));
    stat.walk_end   = (ptr_r >= PW'(BUFFER_COUNT));
    stat.put_bad    = (32'(item_r.buffer_index) >= BUFFER_COUNT) ||
                      (cnt_r[pidx] == '0);
    stat.put_zero   = (cnt_r[pidx] == CW'(1));
    stat.move_end   = item_r.to_front ? (ptr_r == '0)
                                      : (ptr_r >= PW'(BUFFER_COUNT - 1));
    stat.sync_dirty = (ptr_r < PW'(BUFFER_COUNT)) && dirty_r[cur_buf];
    stat.out_full   = ov_r && out_stall;
  end

  always_comb begin
    valid_nxt   = valid_r;
    dirty_nxt   = dirty_r;
    cnt_nxt     = cnt_r;
    lru_nxt     = lru_r;
    busy_nxt    = busy_r;
    ptr_nxt     = ptr_r;
    hit_idx_nxt = hit_idx_r;
    hit_nxt     = hit_r;
    nflush_nxt  = nflush_r;
    ov_nxt      = ov_r && out_stall;
    od_nxt      = od_r;
    tag_we      = 1'b0;
    tag_wa      = cur_buf;

    if (cmd.load) begin
      ptr_nxt    = '0;
      nflush_nxt = '0;
      hit_nxt    = 1'b0;
    end
    if (cmd.match) begin
      for (int i = 0; i < BUFFER_COUNT; i++) begin
        if (!hit_nxt && valid_r[i] && tag_mem[i] == BW'(item_r.block_number)) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = IW'(i);
        end
      end
      if (item_r.command == bbcm_pkg::CMD_PUT) begin
        // locate the released buffer in the chain
        for (int i = 0; i < BUFFER_COUNT; i++) begin
          if (32'(lru_r[i]) == 32'(item_r.buffer_index)) ptr_nxt = PW'(i);
        end
      end
    end
    if (cmd.get_hit) begin
      od_nxt      = '0;
      od_nxt.slot = 4'(hit_idx_r);
      od_nxt.hit  = 1'b1;
      od_nxt.last = 1'b1;
      if (32'(cnt_r[hit_idx_r]) >= MAX_REFERENCES) begin
        od_nxt.error_code = bbcm_pkg::ERR_OVERFLOW;
      end else begin
        if (cnt_r[hit_idx_r] == '0) busy_nxt = busy_r + 1'b1;
        cnt_nxt[hit_idx_r] = cnt_r[hit_idx_r] + 1'b1;
      end
      ov_nxt = 1'b1;
    end
    if (cmd.scan_step) ptr_nxt = ptr_r + 1'b1;
    if (cmd.get_miss) begin
      od_nxt                  = '0;
      od_nxt.slot             = 4'(cur_buf);
      od_nxt.fetch_needed     = item_r.fetch_wanted;
      od_nxt.write_back_valid = dirty_r[cur_buf];
      od_nxt.write_back_block = (dirty_r[cur_buf] && valid_r[cur_buf]) ?
                                16'(cur_tag) : '0;
      od_nxt.last             = 1'b1;
      busy_nxt          = busy_r + 1'b1;
      dirty_nxt[cur_buf] = 1'b0;
      valid_nxt[cur_buf] = 1'b1;
      cnt_nxt[cur_buf]   = CW'(1);
      tag_we            = 1'b1;
      ov_nxt            = 1'b1;
    end
    if (cmd.get_fail) begin
      od_nxt            = '0;
      od_nxt.error_code = bbcm_pkg::ERR_ALL_BUSY;
      od_nxt.last       = 1'b1;
      ov_nxt            = 1'b1;
    end
    if (cmd.put_check) begin
      od_nxt      = '0;
      od_nxt.slot = item_r.buffer_index;
      od_nxt.last = 1'b1;
      if (stat.put_bad) begin
        od_nxt.error_code = bbcm_pkg::ERR_UNUSED;
        ov_nxt            = 1'b1;
      end else begin
        if (item_r.modified) dirty_nxt[pidx] = 1'b1;
        cnt_nxt[pidx] = cnt_r[pidx] - 1'b1;
        if (stat.put_zero && busy_r != '0) busy_nxt = busy_r - 1'b1;
      end
    end
    if (cmd.move_step) begin
      // swap neighbor into place; released buffer bubbles toward the front or the rear, as to_front selects
      if (item_r.to_front) begin
        lru_nxt[ptr_r[IW-1:0]]       = lru_r[ptr_r[IW-1:0] - 1'b1];
        lru_nxt[ptr_r[IW-1:0] - 1'b1] = lru_r[ptr_r[IW-1:0]];
        ptr_nxt = ptr_r - 1'b1;
      end else begin
        lru_nxt[ptr_r[IW-1:0]]       = lru_r[ptr_r[IW-1:0] + 1'b1];
        lru_nxt[ptr_r[IW-1:0] + 1'b1] = lru_r[ptr_r[IW-1:0]];
        ptr_nxt = ptr_r + 1'b1;
      end
    end
    if (cmd.put_done) begin
      if (item_r.write_now && dirty_r[pidx] && cnt_r[pidx] == '0) begin
        od_nxt.write_back_valid = 1'b1;
        od_nxt.write_back_block = valid_r[pidx] ? 16'(pidx_tag) : '0;
        dirty_nxt[pidx] = 1'b0;
      end
      ov_nxt = 1'b1;
    end
    if (cmd.sync_step) begin
      if (stat.sync_dirty) begin
        od_nxt                  = '0;
        od_nxt.slot             = 4'(cur_buf);
        od_nxt.write_back_valid = 1'b1;
        od_nxt.write_back_block = valid_r[cur_buf] ? 16'(cur_tag) : '0;
        dirty_nxt[cur_buf] = 1'b0;
        nflush_nxt = nflush_r + 1'b1;
        ov_nxt     = 1'b1;
      end
      ptr_nxt = ptr_r + 1'b1;
    end
    if (cmd.sync_done) begin
      od_nxt               = '0;
      od_nxt.flushed_total = 5'(nflush_r);
      od_nxt.last          = 1'b1;
      ov_nxt               = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_data;
    if (tag_we) tag_mem[tag_wa] <= BW'(item_r.block_number);
    od_r <= od_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      dirty_r   <= '0;
      busy_r    <= '0;
      ptr_r     <= '0;
      hit_r     <= 1'b0;
      hit_idx_r <= '0;
      nflush_r  <= '0;
      ov_r      <= 1'b0;
      for (int i = 0; i < BUFFER_COUNT; i++) begin
        cnt_r[i] <= '0;
        lru_r[i] <= IW'(i);
      end
    end else begin
      valid_r   <= valid_nxt;
      dirty_r   <= dirty_nxt;
      busy_r    <= busy_nxt;
      ptr_r     <= ptr_nxt;
      hit_r     <= hit_nxt;
      hit_idx_r <= hit_idx_nxt;
      nflush_r  <= nflush_nxt;
      ov_r      <= ov_nxt;
      cnt_r     <= cnt_nxt;
      lru_r     <= lru_nxt;
    end
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule

// ===== rtl/core/bbcm_ctrl.sv =====
// ============================================================================
// bbcm_ctrl: command sequencer
// Steps get, put and sync through match, scan, chain move and result phases.
// ============================================================================
module bbcm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bbcm_pkg::in_item_t in_data,
  output bbcm_pkg::dp_cmd_t  cmd,
  input  bbcm_pkg::dp_stat_t stat
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_MATCH = 9'b000000010,
    S_GET   = 9'b000000100,
    S_SCAN  = 9'b000001000,
    S_PUT   = 9'b000010000,
    S_MOVE  = 9'b000100000,
    S_PDONE = 9'b001000000,
    S_SYNC  = 9'b010000000,
    S_WAIT  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0] op_r, op_nxt;

  assign in_stall = (state_r != S_IDLE) || stat.out_full;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && !stat.out_full) begin
          cmd.load = 1'b1;
          op_nxt   = in_data.command;
          if (in_data.command != bbcm_pkg::CMD_NONE) state_nxt = S_MATCH;
        end
      end
      S_MATCH: begin
        cmd.match = 1'b1;
        unique case (op_r)
          bbcm_pkg::CMD_GET:  state_nxt = S_GET;
          bbcm_pkg::CMD_PUT:  state_nxt = S_PUT;
          default:            state_nxt = S_SYNC;
        endcase
      end
      S_GET: begin
        if (!stat.out_full) begin
          if (stat.is_hit) begin
            cmd.get_hit = 1'b1;
            state_nxt   = S_IDLE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (!stat.out_full) begin
          if (stat.scan_end) begin
            cmd.get_fail = 1'b1;
            state_nxt    = S_IDLE;
          end else if (stat.scan_found) begin
            cmd.get_miss = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            cmd.scan_step = 1'b1;
          end
        end
      end
      S_PUT: begin
        if (!stat.out_full) begin
          cmd.put_check = 1'b1;
          if (stat.put_bad) state_nxt = S_IDLE;
          else if (stat.put_zero) state_nxt = S_MOVE;
          else state_nxt = S_PDONE;
        end
      end
      S_MOVE: begin
        if (stat.move_end) state_nxt = S_PDONE;
        else cmd.move_step = 1'b1;
      end
      S_PDONE: begin
        cmd.put_done = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_SYNC: begin
        // walk the whole chain regardless of how many buffers are busy
        if (!stat.out_full) begin
          if (stat.walk_end) begin
            cmd.sync_done = 1'b1;
            state_nxt     = S_WAIT;
          end else begin
            cmd.sync_step = 1'b1;
          end
        end
      end
      S_WAIT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= bbcm_pkg::CMD_GET;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

endmodule

// ===== rtl/core/block_buffer_cache_manager.sv =====
// ============================================================================
// block_buffer_cache_manager: LRU buffer tag manager with reference counts
// Sequencer plus storage datapath; one command at a time.
// ============================================================================
//  channel | ports                       | direction
//  input   | in_valid in_stall in_data   | command in
//  output  | out_valid out_stall out_data| results out
//
//  get hit: tag match only; get miss: scans LRU positions for a free buffer.
//  put: moves the buffer along the chain when its count hits zero.
//  sync: walks all BUFFER_COUNT positions, one result per dirty buffer plus a total.
//  Synchronous active-low reset; a stalled result holds the sequencer in place
//  for as long as it lasts.
module block_buffer_cache_manager #(
  parameter int unsigned BUFFER_COUNT      = bbcm_pkg::BUFFER_COUNT_DEF,
  parameter int unsigned BLOCK_NUMBER_BITS = bbcm_pkg::BLOCK_NUMBER_BITS_DEF,
  parameter int unsigned MAX_REFERENCES    = bbcm_pkg::MAX_REFERENCES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bbcm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bbcm_pkg::out_item_t out_data
);

  bbcm_pkg::dp_cmd_t  cmd;
  bbcm_pkg::dp_stat_t stat;

  bbcm_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .cmd, .stat
  );

  bbcm_datapath #(
    .BUFFER_COUNT(BUFFER_COUNT),
    .BLOCK_NUMBER_BITS(BLOCK_NUMBER_BITS),
    .MAX_REFERENCES(MAX_REFERENCES)
  ) u_dp (
    .clk, .rst_n, .in_data, .cmd, .stat, .out_valid, .out_stall, .out_data
  );

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed under stall");
  a_busy_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while result stalled");
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.get_hit, cmd.get_miss, cmd.get_fail, cmd.put_done,
                cmd.sync_done}) <= 1)
    else $error("two result commands at once");

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: block buffer cache manager regression
// Drives get/put/sync commands through a queue-fed driver, predicts results
// with a local LRU/refcount model and checks every output transfer in order.
// ----------------------------------------------------------------------------
module tb;

  localparam int NBUF = 16;
  localparam int MAXREF = 255;
  localparam int WDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  bbcm_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  bbcm_pkg::out_item_t out_data;

  block_buffer_cache_manager dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #10 clk = ~clk;

  // cache state mirror
  logic [15:0] tags [NBUF];
  logic        tvalid [NBUF];
  logic        dirty [NBUF];
  int          refs [NBUF];
  int          chain [NBUF];
  int          busy;

  bbcm_pkg::in_item_t  cmd_q [$];
  bbcm_pkg::out_item_t expected_q [$];
  int  mismatches = 0;
  bit  sent_all = 1'b0;
  bit  calm = 1'b0;       // no idling on either side
  bit  hold_out = 1'b0;   // long receiver hold-off requested
  bit  pause_in = 1'b0;   // sender waits for drain
  int  wdog = 0;

  function automatic bbcm_pkg::out_item_t mk(int s, bit h, bit f, bit wv,
                                             logic [15:0] wb, bbcm_pkg::err_t e,
                                             int fc, bit l);
    bbcm_pkg::out_item_t r;
    r.slot = s[3:0]; r.hit = h; r.fetch_needed = f; r.write_back_valid = wv;
    r.write_back_block = wb; r.error_code = e; r.flushed_total = fc[4:0];
    r.last = l;
    return r;
  endfunction

  task automatic reset_cache();
    for (int i = 0; i < NBUF; i++) begin
      tags[i] = '0; tvalid[i] = 0; dirty[i] = 0; refs[i] = 0; chain[i] = i;
    end
    busy = 0;
  endtask

  task automatic predict_cache(input bbcm_pkg::in_item_t it);
    int b, pos, n;
    bit done;
    done = 0;
    case (it.command)
      bbcm_pkg::CMD_GET: begin
        for (int i = 0; i < NBUF && !done; i++)
          if (tvalid[i] && tags[i] == it.block_number) begin
            done = 1;
            if (refs[i] >= MAXREF)
              expected_q.push_back(mk(i, 1, 0, 0, 0, bbcm_pkg::ERR_OVERFLOW, 0, 1));
            else begin
              if (refs[i] == 0) busy++;
              refs[i]++;
              expected_q.push_back(mk(i, 1, 0, 0, 0, bbcm_pkg::ERR_OK, 0, 1));
            end
          end
        if (!done && busy < NBUF)
          for (int i = 0; i < NBUF && !done; i++) begin
            b = chain[i];
            if (refs[b] == 0) begin
              done = 1;
              expected_q.push_back(mk(b, 0, it.fetch_wanted, dirty[b],
                                      dirty[b] ? tags[b] : 16'h0, bbcm_pkg::ERR_OK,
                                      0, 1));
              busy++; dirty[b] = 0; tags[b] = it.block_number; tvalid[b] = 1;
              refs[b] = 1;
            end
          end
        if (!done) expected_q.push_back(mk(0, 0, 0, 0, 0, bbcm_pkg::ERR_ALL_BUSY, 0, 1));
      end
      bbcm_pkg::CMD_PUT: begin
        b = it.buffer_index;
        if (refs[b] == 0)
          expected_q.push_back(mk(b, 0, 0, 0, 0, bbcm_pkg::ERR_UNUSED, 0, 1));
        else begin
          bit wv;
          logic [15:0] wb;
          wv = 0; wb = '0;
          if (it.modified) dirty[b] = 1;
          refs[b]--;
          if (refs[b] == 0) begin
            if (busy > 0) busy--;
            pos = 0;
            for (int i = 0; i < NBUF; i++) if (chain[i] == b) pos = i;
            if (it.to_front) begin
              for (int i = pos; i > 0; i--) chain[i] = chain[i-1];
              chain[0] = b;
            end else begin
              for (int i = pos; i < NBUF-1; i++) chain[i] = chain[i+1];
              chain[NBUF-1] = b;
            end
            if (it.write_now && dirty[b]) begin
              wv = 1; wb = tags[b]; dirty[b] = 0;
            end
          end
          expected_q.push_back(mk(b, 0, 0, wv, wb, bbcm_pkg::ERR_OK, 0, 1));
        end
      end
      bbcm_pkg::CMD_SYNC: begin
        n = 0;
        for (int i = 0; i < NBUF; i++) begin
          b = chain[i];
          if (dirty[b]) begin
            expected_q.push_back(mk(b, 0, 0, 1, tags[b], bbcm_pkg::ERR_OK, 0, 0));
            dirty[b] = 0; n++;
          end
        end
        expected_q.push_back(mk(0, 0, 0, 0, 0, bbcm_pkg::ERR_OK, n, 1));
      end
      default: ;
    endcase
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (!(in_valid && in_stall)) begin
        if (in_valid) begin
          predict_cache(in_data);
          void'(cmd_q.pop_front());
        end
        if (cmd_q.size() > 0 && !pause_in && (calm || $urandom_range(99) >= 18)) begin
          in_valid <= 1'b1;
          in_data <= cmd_q[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_data);
        end else begin
          bbcm_pkg::out_item_t e;
          e = expected_q.pop_front();
          if (e !== out_data) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch exp %p act %p", e, out_data);
          end
        end
      end
      out_stall <= hold_out || (!calm && $urandom_range(99) < 18);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) wdog <= 0;
      else wdog <= wdog + 1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (wdog >= WDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // long receiver hold-off, counted here
  initial begin
    wait (sent_all === 1'b0 && rst_n === 1'b1);
    repeat (300) @(posedge clk);
    hold_out = 1'b1;
    repeat (400) @(posedge clk);
    hold_out = 1'b0;
  end

  // random block numbers from a small pool so hits happen often
  function automatic logic [15:0] pick_block();
    case ($urandom_range(9))
      0: return 16'(($urandom_range(1)) ? 16'hFFFF : 16'h0000);
      1: return 16'($urandom);
      default: return 16'($urandom_range(23)) ^ 16'hA5C0;
    endcase
  endfunction

  task automatic add_cmd(bbcm_pkg::cmd_t c, logic [15:0] blk, bit f, int bi, bit os,
                         bit wi, bit md);
    bbcm_pkg::in_item_t it;
    it.command = c; it.block_number = blk; it.fetch_wanted = f;
    it.buffer_index = bi[3:0]; it.to_front = os; it.write_now = wi; it.modified = md;
    cmd_q.push_back(it);
  endtask

  task automatic wait_drained();
    wait (cmd_q.size() == 0 && !in_valid);
    wait (expected_q.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    reset_cache();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    // directed: extremes, every command, error cases
    add_cmd(bbcm_pkg::CMD_PUT, 16'h0, 0, 15, 0, 0, 1);        // put of unused buffer
    add_cmd(bbcm_pkg::CMD_SYNC, 16'h0, 0, 0, 0, 0, 0);        // empty sync
    add_cmd(bbcm_pkg::CMD_NONE, 16'hFFFF, 1, 15, 1, 1, 1);    // ignored command
    add_cmd(bbcm_pkg::CMD_GET, 16'h0000, 1, 0, 0, 0, 0);
    add_cmd(bbcm_pkg::CMD_GET, 16'hFFFF, 0, 0, 0, 0, 0);
    add_cmd(bbcm_pkg::CMD_GET, 16'hFFFF, 1, 0, 0, 0, 0);      // hit
    add_cmd(bbcm_pkg::CMD_PUT, 16'h0, 0, 1, 0, 0, 1);         // still referenced
    add_cmd(bbcm_pkg::CMD_PUT, 16'h0, 0, 1, 1, 1, 0);         // reaches zero, write back
    add_cmd(bbcm_pkg::CMD_PUT, 16'h0, 0, 0, 0, 0, 1);         // dirty, to rear
    add_cmd(bbcm_pkg::CMD_SYNC, 16'h0, 0, 0, 0, 0, 0);
    for (int i = 0; i < 16; i++)
      add_cmd(bbcm_pkg::CMD_GET, 16'h100 + 16'(i), i[0], 0, 0, 0, 0);
    add_cmd(bbcm_pkg::CMD_GET, 16'h7777, 1, 0, 0, 0, 0);      // all busy
    wait_drained();
    // saturate one count: 254 more hits, then overflow; that buffer stays held
    for (int i = 0; i < 255; i++) add_cmd(bbcm_pkg::CMD_GET, 16'h100, 0, 0, 0, 0, 0);
    for (int i = 0; i < 16; i++)
      add_cmd(bbcm_pkg::CMD_PUT, 16'h0, 0, i, $urandom_range(1), 0, $urandom_range(1));
    add_cmd(bbcm_pkg::CMD_SYNC, 16'h0, 0, 0, 0, 0, 0);
    wait_drained();
    // sender pause until everything has drained
    pause_in = 1'b1;
    wait (expected_q.size() == 0);
    pause_in = 1'b0;
    // random: mostly gets and puts of random buffer indices, some syncs and ignored commands
    calm = 1'b1;
    for (int n = 0; n < 180; n++) begin
      int r;
      if (n == 60) begin
        wait_drained();
        calm = 1'b0;
      end
      r = $urandom_range(99);
      if (r < 45)
        add_cmd(bbcm_pkg::CMD_GET, pick_block(), $urandom_range(1), $urandom_range(15),
                $urandom_range(1), $urandom_range(1), $urandom_range(1));
      else if (r < 88)
        add_cmd(bbcm_pkg::CMD_PUT, 16'($urandom), $urandom_range(1), $urandom_range(15),
                $urandom_range(1), $urandom_range(1), $urandom_range(1));
      else if (r < 96)
        add_cmd(bbcm_pkg::CMD_SYNC, 16'($urandom), $urandom_range(1), $urandom_range(15),
                $urandom_range(1), $urandom_range(1), $urandom_range(1));
      else
        add_cmd(bbcm_pkg::CMD_NONE, 16'($urandom), $urandom_range(1), $urandom_range(15),
                $urandom_range(1), $urandom_range(1), $urandom_range(1));
      if (cmd_q.size() > 40) wait (cmd_q.size() < 10);
    end
    sent_all = 1'b1;
    wait (cmd_q.size() == 0 && !in_valid);
    wait (expected_q.size() == 0);
    repeat (60) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
